[sv/dqir_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqir_pkg
// Shared sizes, types and codes for the DNS query ID remap table.
// ----------------------------------------------------------------------------
package dqir_pkg;

   // Number of slots in the remap table (2 to 32768).
   localparam int TABLE_ENTRIES = 512;

   // Width of a DNS transaction ID.
   localparam int ID_BITS = 16;

   // Slot index field in the low ID bits, and the issued high part above it.
   localparam int IDX_BITS  = (TABLE_ENTRIES <= 2) ? 1 : $clog2(TABLE_ENTRIES);
   localparam int HIGH_BITS = ID_BITS - IDX_BITS;

   // Command codes.
   localparam logic CMD_QUERY = 1'b0;
   localparam logic CMD_REPLY = 1'b1;

   // One table entry as held in the slot memory.
   typedef struct packed {
      logic                 valid;
      logic [ID_BITS-1:0]   original_id;
      logic [HIGH_BITS-1:0] issued_high;
      logic [31:0]          client_addr;
      logic [15:0]          client_port;
      logic [31:0]          server_addr;
      logic [15:0]          server_port;
   } entry_type;

   // Control states of the table sequencer.
   typedef enum logic {
      ST_IDLE,
      ST_RESOLVE
   } state_type;

endpackage

[sv/dns_query_id_remap_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_query_id_remap_table
// Rewrites DNS transaction IDs through a slot table: queries take the next
// slot and get a new ID, replies find their slot by ID and get the original.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Contents
//  req_*     in         req_valid/stall    command, flags, ID, addresses, ports
//  rsp_*     out        rsp_valid/stall    accept flag, ID, reversed addresses
//
// Each request passes the accepting edge, which reads its slot from the slot
// memory, and then the resolve state, which checks the entry, writes it back
// and loads the result register. The sequencer keeps one request in flight,
// so a read never meets a pending write. A stalled result register holds the
// request in the resolve state and so delays the next request.
// Reset clears the sequencer, the slot counter, its wrap flag and the result
// valid. The memory is not cleared: slots not yet reached by the counter
// since reset read as empty, so no clearing pass is needed.

module dns_query_id_remap_table import dqir_pkg::*; (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_cmd,
   input  logic                req_is_reply,
   input  logic [ID_BITS-1:0]  req_dns_ident,
   input  logic [31:0]         req_src_addr,
   input  logic [15:0]         req_src_port,
   input  logic [31:0]         req_dst_addr,
   input  logic [15:0]         req_dst_port,
   input  logic [15:0]         req_random_bits,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_accepted,
   output logic [ID_BITS-1:0]  rsp_out_ident,
   output logic [31:0]         rsp_out_src_addr,
   output logic [15:0]         rsp_out_src_port,
   output logic [31:0]         rsp_out_dst_addr,
   output logic [15:0]         rsp_out_dst_port
);

   state_type            state_ff, state_in;
   logic [IDX_BITS-1:0]  next_slot_ff, next_slot_in;
   logic                 wrapped_ff, wrapped_in;

   // Latched request.
   logic                 cmd_ff, is_reply_ff;
   logic [ID_BITS-1:0]   ident_ff;
   logic [31:0]          src_addr_ff, dst_addr_ff;
   logic [15:0]          src_port_ff, dst_port_ff;
   logic [HIGH_BITS-1:0] rnd_high_ff;

   // Slot memory.
   entry_type            mem [TABLE_ENTRIES];
   entry_type            rd_data_ff;
   logic [IDX_BITS-1:0]  rd_addr;
   logic                 rd_in_range;
   logic                 wr_en;
   logic [IDX_BITS-1:0]  wr_addr;
   entry_type            wr_data;

   // Resolve stage.
   logic                 req_accept;
   logic                 out_load;
   logic [IDX_BITS-1:0]  reply_slot;
   logic                 slot_in_range;
   logic                 slot_written;
   logic                 query_ok;
   logic                 reply_hit;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_accepted_ff;
   logic [ID_BITS-1:0]   rsp_ident_ff;
   logic [31:0]          rsp_src_addr_ff, rsp_dst_addr_ff;
   logic [15:0]          rsp_src_port_ff, rsp_dst_port_ff;

   assign req_accept = req_valid && !req_stall;

   // Replies look up the slot named by the low ID bits.
   assign rd_addr     = req_dns_ident[IDX_BITS-1:0];
   assign rd_in_range = {1'b0, rd_addr} < (IDX_BITS + 1)'(TABLE_ENTRIES);

   // Sequencer: one request at a time, result register gates the resolve.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Capture the request when it is taken.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff      <= req_cmd;
         is_reply_ff <= req_is_reply;
         ident_ff    <= req_dns_ident;
         src_addr_ff <= req_src_addr;
         src_port_ff <= req_src_port;
         dst_addr_ff <= req_dst_addr;
         dst_port_ff <= req_dst_port;
         rnd_high_ff <= req_random_bits[ID_BITS-1:IDX_BITS];
      end
   end

   // Slot memory with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (req_accept && rd_in_range) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Match check. A slot counts as written once the counter has passed it.
   always_comb begin
      reply_slot    = ident_ff[IDX_BITS-1:0];
      slot_in_range = {1'b0, reply_slot} < (IDX_BITS + 1)'(TABLE_ENTRIES);
      slot_written  = wrapped_ff || (reply_slot < next_slot_ff);
      query_ok      = (cmd_ff == CMD_QUERY) && !is_reply_ff;
      reply_hit     = (cmd_ff == CMD_REPLY) && is_reply_ff && slot_in_range
                      && slot_written && rd_data_ff.valid
                      && (rd_data_ff.issued_high == ident_ff[ID_BITS-1:IDX_BITS]);
   end

   // Write back: a query fills the counter's slot, a hit clears its slot.
   always_comb begin
      wr_en   = out_load && (query_ok || reply_hit);
      wr_addr = query_ok ? next_slot_ff : reply_slot;
      if (query_ok) begin
         wr_data.valid       = 1'b1;
         wr_data.original_id = ident_ff;
         wr_data.issued_high = rnd_high_ff;
         wr_data.client_addr = src_addr_ff;
         wr_data.client_port = src_port_ff;
         wr_data.server_addr = dst_addr_ff;
         wr_data.server_port = dst_port_ff;
      end else begin
         wr_data       = rd_data_ff;
         wr_data.valid = 1'b0;
      end
   end

   // Slot counter wraps at the table size.
   always_comb begin
      next_slot_in = next_slot_ff;
      wrapped_in   = wrapped_ff;
      if (out_load && query_ok) begin
         if (next_slot_ff == IDX_BITS'(TABLE_ENTRIES - 1)) begin
            next_slot_in = '0;
            wrapped_in   = 1'b1;
         end else begin
            next_slot_in = next_slot_ff + IDX_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_slot_ff <= '0;
         wrapped_ff   <= 1'b0;
      end else begin
         next_slot_ff <= next_slot_in;
         wrapped_ff   <= wrapped_in;
      end
   end

   // Result register valid.
   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload: new ID for a query, restored ID and swapped ends for a hit.
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_accepted_ff <= query_ok || reply_hit;
         rsp_src_addr_ff <= '0;
         rsp_src_port_ff <= '0;
         rsp_dst_addr_ff <= '0;
         rsp_dst_port_ff <= '0;
         if (query_ok) begin
            rsp_ident_ff <= {rnd_high_ff, next_slot_ff};
         end else if (reply_hit) begin
            rsp_ident_ff    <= rd_data_ff.original_id;
            rsp_src_addr_ff <= rd_data_ff.server_addr;
            rsp_src_port_ff <= rd_data_ff.server_port;
            rsp_dst_addr_ff <= rd_data_ff.client_addr;
            rsp_dst_port_ff <= rd_data_ff.client_port;
         end else begin
            rsp_ident_ff <= '0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_out_ident    = rsp_ident_ff;
   assign rsp_out_src_addr = rsp_src_addr_ff;
   assign rsp_out_src_port = rsp_src_port_ff;
   assign rsp_out_dst_addr = rsp_dst_addr_ff;
   assign rsp_out_dst_port = rsp_dst_port_ff;

endmodule

[sv/dqir_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqir_checker
// Port-level checks for the DNS query ID remap table, bound to the top level.
// ----------------------------------------------------------------------------
module dqir_checker import dqir_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_accepted,
   input logic [ID_BITS-1:0] rsp_out_ident,
   input logic [31:0]        rsp_out_src_addr,
   input logic [15:0]        rsp_out_src_port,
   input logic [31:0]        rsp_out_dst_addr,
   input logic [15:0]        rsp_out_dst_port
);

   // A stalled result holds its valid, accept flag, ID and both addresses.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_accepted)
         && $stable(rsp_out_ident) && $stable(rsp_out_src_addr)
         && $stable(rsp_out_dst_addr))
      else $error("stalled result changed");

   // A taken request blocks the next one while it resolves.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while one is in flight");

   // A new result only appears out of a request in flight.
   a_rsp_from_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a request");

   // A rejected request reports all-zero fields.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> rsp_out_ident == '0
         && rsp_out_src_addr == '0 && rsp_out_src_port == '0
         && rsp_out_dst_addr == '0 && rsp_out_dst_port == '0)
      else $error("rejected result carries data");

endmodule

bind dns_query_id_remap_table dqir_checker u_dqir_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_accepted     (rsp_accepted),
   .rsp_out_ident    (rsp_out_ident),
   .rsp_out_src_addr (rsp_out_src_addr),
   .rsp_out_src_port (rsp_out_src_port),
   .rsp_out_dst_addr (rsp_out_dst_addr),
   .rsp_out_dst_port (rsp_out_dst_port)
);

[tb/dns_query_id_remap_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_query_id_remap_table_tb
// Self-checking bench for the DNS query ID remap table. Queries and replies
// are pushed through the request channel with random gaps and result stalls.
// A local model of the slot table predicts every result, and each result is
// compared field by field in arrival order.
// ----------------------------------------------------------------------------
module dns_query_id_remap_table_tb import dqir_pkg::*; ();

   localparam int CLOCK_PERIOD   = 8;
   localparam int RESET_CYCLES   = 10;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int RANDOM_ITEMS   = 80;
   localparam int QUIET_FIRST    = 20;
   localparam int QUIET_LAST     = 60;
   localparam int HOLD_CYCLES    = 300;
   localparam int IDLE_PERCENT   = 15;

   // One request as offered on the req_ channel.
   typedef struct packed {
      logic                cmd;
      logic                is_reply;
      logic [ID_BITS-1:0]  ident;
      logic [31:0]         src_addr;
      logic [15:0]         src_port;
      logic [31:0]         dst_addr;
      logic [15:0]         dst_port;
      logic [15:0]         random_bits;
   } dns_request_type;

   // One result as seen on the rsp_ channel.
   typedef struct packed {
      logic                accepted;
      logic [ID_BITS-1:0]  ident;
      logic [31:0]         src_addr;
      logic [15:0]         src_port;
      logic [31:0]         dst_addr;
      logic [15:0]         dst_port;
   } dns_result_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic                req_cmd;
   logic                req_is_reply;
   logic [ID_BITS-1:0]  req_dns_ident;
   logic [31:0]         req_src_addr;
   logic [15:0]         req_src_port;
   logic [31:0]         req_dst_addr;
   logic [15:0]         req_dst_port;
   logic [15:0]         req_random_bits;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_accepted;
   logic [ID_BITS-1:0]  rsp_out_ident;
   logic [31:0]         rsp_out_src_addr;
   logic [15:0]         rsp_out_src_port;
   logic [31:0]         rsp_out_dst_addr;
   logic [15:0]         rsp_out_dst_port;

   // Shared bench controls.
   logic                idle_enable;
   int                  rsp_hold_left;
   int                  mismatch_count;
   int                  cycle_count;

   // Local copy of the slot table.
   logic                entry_live        [TABLE_ENTRIES];
   logic [ID_BITS-1:0]  entry_orig_id     [TABLE_ENTRIES];
   logic [HIGH_BITS-1:0] entry_high       [TABLE_ENTRIES];
   logic [31:0]         entry_client_addr [TABLE_ENTRIES];
   logic [15:0]         entry_client_port [TABLE_ENTRIES];
   logic [31:0]         entry_server_addr [TABLE_ENTRIES];
   logic [15:0]         entry_server_port [TABLE_ENTRIES];
   logic [IDX_BITS-1:0] slot_ptr;

   // Results still to arrive, and IDs handed out for queries.
   dns_result_type      pending_results [$];
   logic [ID_BITS-1:0]  issued_ids [$];

   dns_query_id_remap_table DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_is_reply     (req_is_reply),
      .req_dns_ident    (req_dns_ident),
      .req_src_addr     (req_src_addr),
      .req_src_port     (req_src_port),
      .req_dst_addr     (req_dst_addr),
      .req_dst_port     (req_dst_port),
      .req_random_bits  (req_random_bits),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_accepted     (rsp_accepted),
      .rsp_out_ident    (rsp_out_ident),
      .rsp_out_src_addr (rsp_out_src_addr),
      .rsp_out_src_port (rsp_out_src_port),
      .rsp_out_dst_addr (rsp_out_dst_addr),
      .rsp_out_dst_port (rsp_out_dst_port)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Watchdog: end the run if it goes on far beyond any correct run.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   // Clear the local table the way reset clears the block.
   function automatic void clear_table_model();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         entry_live[i] = 1'b0;
      end
      slot_ptr = '0;
   endfunction

   // Work out the result of one request and update the local table.
   function automatic dns_result_type translate_request(input dns_request_type r);
      dns_result_type      res;
      logic [IDX_BITS-1:0] slot;
      logic [ID_BITS-1:0]  new_id;
      res = '0;
      if (r.cmd == CMD_QUERY) begin
         if (!r.is_reply) begin
            slot     = slot_ptr;
            new_id   = {r.random_bits[ID_BITS-1:IDX_BITS], slot};
            slot_ptr = (int'(slot) == TABLE_ENTRIES - 1) ? '0 : slot + IDX_BITS'(1);
            entry_live[slot]        = 1'b1;
            entry_orig_id[slot]     = r.ident;
            entry_high[slot]        = new_id[ID_BITS-1:IDX_BITS];
            entry_client_addr[slot] = r.src_addr;
            entry_client_port[slot] = r.src_port;
            entry_server_addr[slot] = r.dst_addr;
            entry_server_port[slot] = r.dst_port;
            res.accepted = 1'b1;
            res.ident    = new_id;
         end
      end else begin
         slot = r.ident[IDX_BITS-1:0];
         if (r.is_reply && int'(slot) < TABLE_ENTRIES && entry_live[slot] &&
             entry_high[slot] == r.ident[ID_BITS-1:IDX_BITS]) begin
            // Matched reply: free the slot and send back the reversed flow.
            entry_live[slot] = 1'b0;
            res.accepted = 1'b1;
            res.ident    = entry_orig_id[slot];
            res.src_addr = entry_server_addr[slot];
            res.src_port = entry_server_port[slot];
            res.dst_addr = entry_client_addr[slot];
            res.dst_port = entry_client_port[slot];
         end
      end
      return res;
   endfunction

   // Random 32-bit address, now and then one of the extremes.
   function automatic logic [31:0] pick_addr();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) return 32'h0000_0000;
      if (sel == 1) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   // Random 16-bit word, now and then one of the extremes.
   function automatic logic [15:0] pick_word();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) return 16'h0000;
      if (sel == 1) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   // A query with random content.
   function automatic dns_request_type make_query();
      dns_request_type r;
      r.cmd         = CMD_QUERY;
      r.is_reply    = 1'b0;
      r.ident       = pick_word();
      r.src_addr    = pick_addr();
      r.src_port    = pick_word();
      r.dst_addr    = pick_addr();
      r.dst_port    = pick_word();
      r.random_bits = pick_word();
      return r;
   endfunction

   // A reply carrying the given ID; the remaining fields are noise.
   function automatic dns_request_type make_reply(input logic [ID_BITS-1:0] ident);
      dns_request_type r;
      r          = make_query();
      r.cmd      = CMD_REPLY;
      r.is_reply = 1'b1;
      r.ident    = ident;
      return r;
   endfunction

   // Take one issued ID out of the pool at random.
   function automatic logic [ID_BITS-1:0] take_issued_id();
      int                 pos;
      logic [ID_BITS-1:0] id;
      pos = $urandom_range(0, issued_ids.size() - 1);
      id  = issued_ids[pos];
      issued_ids.delete(pos);
      return id;
   endfunction

   // Change at least one of the issued high bits of an ID.
   function automatic logic [ID_BITS-1:0] spoil_high(input logic [ID_BITS-1:0] id);
      logic [HIGH_BITS-1:0] flip;
      flip = HIGH_BITS'($urandom_range(1, (1 << HIGH_BITS) - 1));
      return id ^ {flip, {IDX_BITS{1'b0}}};
   endfunction

   // Offer one request, wait for it to be taken and record its prediction.
   task automatic send_request(input dns_request_type r, output dns_result_type res);
      @(negedge clock);
      while (idle_enable && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_cmd         <= r.cmd;
      req_is_reply    <= r.is_reply;
      req_dns_ident   <= r.ident;
      req_src_addr    <= r.src_addr;
      req_src_port    <= r.src_port;
      req_dst_addr    <= r.dst_addr;
      req_dst_port    <= r.dst_port;
      req_random_bits <= r.random_bits;
      req_valid       <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      res = translate_request(r);
      pending_results.push_back(res);
      if (r.cmd == CMD_QUERY && res.accepted) begin
         issued_ids.push_back(res.ident);
      end
   endtask

   // Compare one result field.
   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s expected %h actual %h", name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   // Result checker: every result taken is compared with the oldest prediction.
   always @(posedge clock) begin
      dns_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result arrived with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("accepted", 32'(want.accepted), 32'(rsp_accepted));
            check_field("out_ident", 32'(want.ident), 32'(rsp_out_ident));
            check_field("out_src_addr", want.src_addr, rsp_out_src_addr);
            check_field("out_src_port", 32'(want.src_port), 32'(rsp_out_src_port));
            check_field("out_dst_addr", want.dst_addr, rsp_out_dst_addr);
            check_field("out_dst_port", 32'(want.dst_port), 32'(rsp_out_dst_port));
         end
      end
   end

   // Result receiver: random stalls, plus a long hold-off when asked for.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_left--;
         end else begin
            rsp_stall <= idle_enable && ($urandom_range(0, 99) < IDLE_PERCENT);
         end
      end
   end

   // Queries at the field extremes.
   task automatic test_query_extremes();
      dns_request_type r;
      dns_result_type  res;
      r = '0;
      r.cmd = CMD_QUERY;
      send_request(r, res);
      r = '1;
      r.cmd      = CMD_QUERY;
      r.is_reply = 1'b0;
      send_request(r, res);
      r = make_query();
      r.random_bits = 16'hFFFF;
      r.ident       = 16'h0000;
      send_request(r, res);
   endtask

   // Replies restore the stored flow; a second reply to the same ID fails.
   task automatic test_reply_restore();
      dns_result_type     res;
      logic [ID_BITS-1:0] first_id;
      logic [ID_BITS-1:0] second_id;
      first_id  = issued_ids.pop_front();
      second_id = issued_ids.pop_front();
      send_request(make_reply(second_id), res);
      send_request(make_reply(first_id), res);
      send_request(make_reply(first_id), res);
   endtask

   // A query with the reply flag set, and a reply without it, are refused.
   task automatic test_flag_mismatch();
      dns_request_type    r;
      dns_result_type     res;
      logic [ID_BITS-1:0] id;
      send_request(make_query(), res);
      id = res.ident;
      issued_ids.delete(issued_ids.size() - 1);
      r = make_query();
      r.is_reply = 1'b1;
      send_request(r, res);
      r = make_reply(id);
      r.is_reply = 1'b0;
      send_request(r, res);
      send_request(make_reply(id), res);
   endtask

   // Unmatched replies: wrong high bits, extreme IDs, and a slot never used.
   task automatic test_unmatched_reply();
      dns_result_type     res;
      logic [ID_BITS-1:0] id;
      send_request(make_query(), res);
      id = res.ident;
      issued_ids.delete(issued_ids.size() - 1);
      send_request(make_reply(spoil_high(id)), res);
      send_request(make_reply(16'hFFFF), res);
      send_request(make_reply(16'h0000), res);
      send_request(make_reply(ID_BITS'(TABLE_ENTRIES - 2)), res);
      send_request(make_reply(id), res);
   endtask

   // Long result hold-off while requests keep coming.
   task automatic test_backpressure();
      dns_result_type     res;
      logic [ID_BITS-1:0] burst_ids [$];
      idle_enable   = 1'b0;
      rsp_hold_left = HOLD_CYCLES;
      for (int i = 0; i < 20; i++) begin
         send_request(make_query(), res);
         burst_ids.push_back(res.ident);
         issued_ids.delete(issued_ids.size() - 1);
      end
      foreach (burst_ids[i]) begin
         send_request(make_reply(burst_ids[i]), res);
      end
      idle_enable = 1'b1;
   endtask

   // Run the slot counter past its wrap, so slots are reused while valid.
   task automatic test_counter_wrap();
      dns_result_type     res;
      logic [ID_BITS-1:0] stale_id;
      logic [ID_BITS-1:0] recent_ids [$];
      send_request(make_query(), res);
      stale_id = res.ident;
      issued_ids.delete(issued_ids.size() - 1);
      for (int i = 0; i < TABLE_ENTRIES + 2; i++) begin
         send_request(make_query(), res);
         issued_ids.delete(issued_ids.size() - 1);
         if (i >= TABLE_ENTRIES - 3) recent_ids.push_back(res.ident);
      end
      // The old ID now points at a rewritten slot.
      send_request(make_reply(stale_id), res);
      foreach (recent_ids[i]) begin
         send_request(make_reply(recent_ids[i]), res);
      end
   endtask

   // Mostly well-formed query and reply traffic, with some noise.
   task automatic test_random_traffic();
      dns_request_type r;
      dns_result_type  res;
      int              sel;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_enable = !(n >= QUIET_FIRST && n < QUIET_LAST);
         sel = $urandom_range(0, 99);
         if (sel < 50 || issued_ids.size() == 0) begin
            r = make_query();
         end else if (sel < 80) begin
            r = make_reply(take_issued_id());
         end else if (sel < 86) begin
            r = make_reply(spoil_high(take_issued_id()));
         end else if (sel < 90) begin
            r = make_reply(pick_word());
         end else if (sel < 95) begin
            r = make_query();
            r.is_reply = 1'b1;
         end else begin
            r = make_reply(issued_ids[$urandom_range(0, issued_ids.size() - 1)]);
            r.is_reply = 1'b0;
         end
         send_request(r, res);
      end
      idle_enable = 1'b1;
   endtask

   // Main sequence.
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = CMD_QUERY;
      req_is_reply    = 1'b0;
      req_dns_ident   = '0;
      req_src_addr    = '0;
      req_src_port    = '0;
      req_dst_addr    = '0;
      req_dst_port    = '0;
      req_random_bits = '0;
      idle_enable     = 1'b1;
      rsp_hold_left   = 0;
      mismatch_count  = 0;
      clear_table_model();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_query_extremes();
      test_reply_restore();
      test_flag_mismatch();
      test_unmatched_reply();
      test_backpressure();
      test_counter_wrap();
      test_random_traffic();

      @(negedge clock);
      req_valid <= 1'b0;

      // Drain outstanding results, then allow for any stray output.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
